// File: rtl/fpi_pkg.sv
package fpi_pkg;

  localparam int WORD_WIDTH     = 32;
  localparam int FRAC_BITS      = 28;
  localparam int DIGIT_BITS     = 4;
  localparam int N_DIGITS       = WORD_WIDTH / DIGIT_BITS;
  localparam int DIGIT_CNT_BITS = (N_DIGITS > 1) ? $clog2(N_DIGITS) : 1;
  localparam int ITER_BITS      = 12;
  localparam int CFG_INDEX_BITS = 8;
  localparam int CFG_DATA_BITS  = WORD_WIDTH;

  localparam logic [ITER_BITS-1:0] ITER_RESET = ITER_BITS'(100);

  localparam logic [CFG_INDEX_BITS-1:0] CFG_MODE = CFG_INDEX_BITS'(0);
  localparam logic [CFG_INDEX_BITS-1:0] CFG_ITER = CFG_INDEX_BITS'(1);
  localparam logic [CFG_INDEX_BITS-1:0] CFG_CRE  = CFG_INDEX_BITS'(2);
  localparam logic [CFG_INDEX_BITS-1:0] CFG_CIM  = CFG_INDEX_BITS'(3);

  typedef logic signed [WORD_WIDTH-1:0] word_t;

  typedef struct packed {
    logic                 mode;
    logic [ITER_BITS-1:0] iter;
    word_t                cre;
    word_t                cim;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_MUL,
    ST_ADD1,
    ST_ADD2,
    ST_DONE
  } state_t;

endpackage

// File: rtl/fractal_point_iterator_core.sv
// Mandelbrot / Julia point iterator, signed Q4.28 fixed point.
// Points arrive on s_axis (tdata: point_re, point_im). Each point yields one
// item on m_axis: tdata carries final_re, final_im, tuser carries escaped.
// Mode, iteration count and the Julia constant sit behind the cfg write
// channel (index 0 mode, 1 count, 2 c real, 3 c imag); cfg_ready is always
// high and writes are meant to happen between points.
// One point is worked at a time. An iteration loads the three digit-serial
// multipliers, runs 8 digit steps (4 bits of the word per cycle), then one
// rounding and range check, one step to hand the products back, and two
// checked adds.
// The result is offered once the last iteration ends, or sooner when the
// point escapes early.
// The result sits in an output register; s_axis_tready rises again once the
// result is loaded there, so the next point can start while it waits.
// A finished point whose output register is still full waits until the
// receiver takes the earlier item; nothing is dropped under stall.
// Synchronous reset clears the control state, empties the output register
// and restores mode 0, count 100 and a zero Julia constant.
module fractal_point_iterator_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [2*fpi_pkg::WORD_WIDTH-1:0]    s_axis_tdata,  // point_re, point_im
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [2*fpi_pkg::WORD_WIDTH-1:0]    m_axis_tdata,  // final_re, final_im
  output logic                                m_axis_tuser,  // escaped
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [fpi_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [fpi_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
  import fpi_pkg::*;

  localparam int W = WORD_WIDTH;

  cfg_t   cfg;
  state_t state, state_next;

  word_t                z_re, z_im, c_re, c_im;
  word_t                d_re, d_im;
  logic [ITER_BITS-1:0] remain;
  logic                 esc;
  word_t                m_re, m_im;
  logic                 m_esc;
  logic                 m_valid;

  logic  s_fire, out_free, mul_start, mul_done, mul_ovf;
  logic  done_rr, done_ii, done_ri, ovf_rr, ovf_ii, ovf_ri;
  word_t rr, ii, ri;
  word_t in_re, in_im;
  logic [W:0] sum_d, sum_t, sum_nre, sum_nim;
  logic  add1_ovf, add2_ovf;

  fpi_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .cfg      (cfg)
  );

  fpi_serial_mult u_mul_rr (
    .clk(clk), .rst(rst), .start(mul_start), .a(z_re), .b(z_re),
    .done(done_rr), .res(rr), .ovf(ovf_rr)
  );

  fpi_serial_mult u_mul_ii (
    .clk(clk), .rst(rst), .start(mul_start), .a(z_im), .b(z_im),
    .done(done_ii), .res(ii), .ovf(ovf_ii)
  );

  fpi_serial_mult u_mul_ri (
    .clk(clk), .rst(rst), .start(mul_start), .a(z_re), .b(z_im),
    .done(done_ri), .res(ri), .ovf(ovf_ri)
  );

  assign in_re    = word_t'(s_axis_tdata[W-1:0]);
  assign in_im    = word_t'(s_axis_tdata[2*W-1:W]);
  assign s_axis_tready = (state == ST_IDLE);
  assign s_fire   = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_valid || m_axis_tready;
  assign mul_done = done_rr & done_ii & done_ri;
  assign mul_ovf  = ovf_rr | ovf_ii | ovf_ri;

  // checked adds, one extra bit to see leaving the word range
  assign sum_d    = {rr[W-1], rr} - {ii[W-1], ii};
  assign sum_t    = {ri[W-1], ri} + {ri[W-1], ri};
  assign add1_ovf = (sum_d[W] ^ sum_d[W-1]) | (sum_t[W] ^ sum_t[W-1]);
  assign sum_nre  = {d_re[W-1], d_re} + {c_re[W-1], c_re};
  assign sum_nim  = {d_im[W-1], d_im} + {c_im[W-1], c_im};
  assign add2_ovf = (sum_nre[W] ^ sum_nre[W-1]) | (sum_nim[W] ^ sum_nim[W-1]);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    mul_start  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (s_fire) begin
          state_next = (cfg.iter == '0) ? ST_DONE : ST_START;
        end
      end
      ST_START: begin
        mul_start  = 1'b1;
        state_next = ST_MUL;
      end
      ST_MUL: begin
        if (mul_done) begin
          state_next = mul_ovf ? ST_DONE : ST_ADD1;
        end
      end
      ST_ADD1: begin
        state_next = add1_ovf ? ST_DONE : ST_ADD2;
      end
      ST_ADD2: begin
        if (add2_ovf || remain == ITER_BITS'(1)) begin
          state_next = ST_DONE;
        end else begin
          state_next = ST_START;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (s_fire) begin
          remain <= cfg.iter;
          esc    <= 1'b0;
          if (cfg.mode) begin
            z_re <= in_re;
            z_im <= in_im;
            c_re <= cfg.cre;
            c_im <= cfg.cim;
          end else begin
            z_re <= '0;
            z_im <= '0;
            c_re <= in_re;
            c_im <= in_im;
          end
        end
      end
      ST_MUL: begin
        if (mul_done && mul_ovf) begin
          esc <= 1'b1;
        end
      end
      ST_ADD1: begin
        d_re <= word_t'(sum_d[W-1:0]);
        d_im <= word_t'(sum_t[W-1:0]);
        if (add1_ovf) begin
          esc <= 1'b1;
        end
      end
      ST_ADD2: begin
        if (add2_ovf) begin
          esc <= 1'b1;
        end else begin
          z_re   <= word_t'(sum_nre[W-1:0]);
          z_im   <= word_t'(sum_nim[W-1:0]);
          remain <= remain - 1'b1;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          m_re  <= esc ? '0 : z_re;
          m_im  <= esc ? '0 : z_im;
          m_esc <= esc;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (state == ST_DONE && out_free) begin
      m_valid <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid <= 1'b0;
    end
  end

  assign m_axis_tvalid = m_valid;
  assign m_axis_tdata  = {m_im, m_re};
  assign m_axis_tuser  = m_esc;

endmodule

// File: rtl/fpi_cfg_regs.sv
module fpi_cfg_regs (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [fpi_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [fpi_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  output fpi_pkg::cfg_t                       cfg
);
  import fpi_pkg::*;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode <= 1'b0;
      cfg.iter <= ITER_RESET;
      cfg.cre  <= '0;
      cfg.cim  <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_MODE: cfg.mode <= cfg_data[0];
        CFG_ITER: cfg.iter <= cfg_data[ITER_BITS-1:0];
        CFG_CRE:  cfg.cre  <= word_t'(cfg_data[WORD_WIDTH-1:0]);
        CFG_CIM:  cfg.cim  <= word_t'(cfg_data[WORD_WIDTH-1:0]);
        default: ;
      endcase
    end
  end

endmodule

// File: rtl/fpi_serial_mult.sv
// Digit-serial magnitude multiplier, one digit of b per cycle, then a
// finishing step that floors the scaled product and checks the word range.
module fpi_serial_mult (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  fpi_pkg::word_t        a,
  input  fpi_pkg::word_t        b,
  output logic                  done,
  output fpi_pkg::word_t        res,
  output logic                  ovf
);
  import fpi_pkg::*;

  localparam int W  = WORD_WIDTH;
  localparam int QW = 2 * WORD_WIDTH - FRAC_BITS;

  logic [W-1:0]              xmag;
  logic [W-1:0]              ymag;
  logic [W-1:0]              acc;
  logic [W-1:0]              low;
  logic                      neg;
  logic [DIGIT_CNT_BITS-1:0] cnt;
  logic                      run;
  logic                      fin;

  logic [W-1:0]            a_mag;
  logic [W-1:0]            b_mag;
  logic [W+DIGIT_BITS-1:0] sum;
  logic [QW-1:0]           qf;
  logic                    sticky;
  logic [QW:0]             mag;
  logic [QW:0]             lim;

  assign a_mag = a[W-1] ? (~a + 1'b1) : a;
  assign b_mag = b[W-1] ? (~b + 1'b1) : b;

  assign sum = (W+DIGIT_BITS)'(acc)
             + (W+DIGIT_BITS)'(xmag) * (W+DIGIT_BITS)'(ymag[DIGIT_BITS-1:0]);

  // product is {acc, low}; bits below FRAC_BITS only matter for rounding
  assign qf     = {acc, low[W-1:FRAC_BITS]};
  assign sticky = |low[FRAC_BITS-1:0];
  // a negative product floors away from zero on its magnitude
  assign mag    = (QW+1)'(qf) + (QW+1)'(neg & sticky);
  assign lim    = neg ? ((QW+1)'(1) << (W-1)) : (((QW+1)'(1) << (W-1)) - (QW+1)'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        fin <= 1'b0;
      end else if (run) begin
        if (cnt == DIGIT_CNT_BITS'(N_DIGITS - 1)) begin
          run <= 1'b0;
          fin <= 1'b1;
        end
      end else if (fin) begin
        fin  <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      xmag <= a_mag;
      ymag <= b_mag;
      neg  <= a[W-1] ^ b[W-1];
      acc  <= '0;
      low  <= '0;
      cnt  <= '0;
    end else if (run) begin
      acc  <= sum[W+DIGIT_BITS-1:DIGIT_BITS];
      low  <= {sum[DIGIT_BITS-1:0], low[W-1:DIGIT_BITS]};
      ymag <= ymag >> DIGIT_BITS;
      cnt  <= cnt + 1'b1;
    end else if (fin) begin
      ovf <= (mag > lim);
      res <= neg ? word_t'(~mag[W-1:0] + 1'b1) : word_t'(mag[W-1:0]);
    end
  end

endmodule

// File: tb/sv/fractal_point_iterator_core_tb.sv
module fractal_point_iterator_core_tb;
  import fpi_pkg::*;

  localparam logic MODE_MANDELBROT = 1'b0;
  localparam logic MODE_JULIA      = 1'b1;

  localparam int ITEM_TARGET = 1150;
  localparam int CYCLE_LIMIT = 4000000;
  localparam int MAX_REPORTS = 40;

  localparam word_t W_MAX  = {1'b0, {(WORD_WIDTH-1){1'b1}}};
  localparam word_t W_MIN  = {1'b1, {(WORD_WIDTH-1){1'b0}}};
  localparam word_t FP_ONE = word_t'(1 << FRAC_BITS);

  // random coordinate spans: +/-2.25 around the set, +/-0.5 near the origin
  localparam longint SPAN_WIDE   = 9 * (longint'(1) << (FRAC_BITS - 2));
  localparam longint SPAN_NARROW = longint'(1) << (FRAC_BITS - 1);

  typedef struct {
    word_t re;
    word_t im;
    logic  escaped;
  } point_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                         s_axis_tvalid = 1'b0;
  logic                         s_axis_tready;
  logic [2*WORD_WIDTH-1:0]      s_axis_tdata  = '0;  // point_re, point_im
  logic                         m_axis_tvalid;
  logic                         m_axis_tready = 1'b0;
  logic [2*WORD_WIDTH-1:0]      m_axis_tdata;        // final_re, final_im
  logic                         m_axis_tuser;        // escaped
  logic                         cfg_valid     = 1'b0;
  logic                         cfg_ready;
  logic [CFG_INDEX_BITS-1:0]    cfg_index     = '0;
  logic [CFG_DATA_BITS-1:0]     cfg_data      = '0;

  // register copy held by the predictor
  logic                 julia_mode;
  logic [ITER_BITS-1:0] iter_count;
  word_t                c_re;
  word_t                c_im;

  logic [2*WORD_WIDTH-1:0] pending_points[$];
  point_result_t           expected_results[$];

  int   mismatches    = 0;
  int   points_queued = 0;
  int   cycles        = 0;
  int   tx_gap;
  int   rx_stall;
  logic tx_burst;
  logic rx_burst;

  fractal_point_iterator_core DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic bit in_word(longint v);
    return v >= longint'(W_MIN) && v <= longint'(W_MAX);
  endfunction

  // z <- z*z + c, products floored, every step range checked
  function automatic point_result_t iterate_point(word_t p_re, word_t p_im);
    longint        zr, zi, cr, ci, rr, ii, ri, nr, ni;
    int            k;
    bit            esc;
    point_result_t res;
    esc = 1'b0;
    if (julia_mode == MODE_JULIA) begin
      zr = p_re; zi = p_im; cr = c_re; ci = c_im;
    end else begin
      zr = 0; zi = 0; cr = p_re; ci = p_im;
    end
    for (k = 0; k < iter_count; k++) begin
      rr = (zr * zr) >>> FRAC_BITS;
      ii = (zi * zi) >>> FRAC_BITS;
      ri = (zr * zi) >>> FRAC_BITS;
      nr = rr - ii;
      esc = !in_word(rr) || !in_word(ii) || !in_word(ri) || !in_word(nr);
      nr = nr + cr;
      ni = ri + ri;
      esc = esc || !in_word(nr) || !in_word(ni);
      ni = ni + ci;
      esc = esc || !in_word(ni);
      if (esc) break;
      zr = nr;
      zi = ni;
    end
    if (esc) begin
      res.re = '0;
      res.im = '0;
      res.escaped = 1'b1;
    end else begin
      res.re = zr[WORD_WIDTH-1:0];
      res.im = zi[WORD_WIDTH-1:0];
      res.escaped = 1'b0;
    end
    return res;
  endfunction

  function automatic word_t rand_coord();
    case ($urandom_range(0, 9))
      0, 1:    return word_t'($urandom());
      2, 3:    return word_t'(longint'($urandom_range(0, 2 * SPAN_NARROW)) - SPAN_NARROW);
      default: return word_t'(longint'($urandom_range(0, 2 * SPAN_WIDE)) - SPAN_WIDE);
    endcase
  endfunction

  // point driver
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      tx_gap <= 0;
      tx_burst <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (tx_gap > 0) begin
        s_axis_tvalid <= 1'b0;
        tx_gap <= tx_gap - 1;
      end else if (pending_points.size() > 0) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= pending_points.pop_front();
        tx_gap <= tx_burst ? 0 : $urandom_range(0, 8);
        if ($urandom_range(0, 29) == 0) tx_burst <= !tx_burst;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // result receiver; a stall only counts down while a result is on offer
  always @(posedge clk) begin : rx_side
    int draw;
    if (rst) begin
      m_axis_tready <= 1'b0;
      rx_stall <= 0;
      rx_burst <= 1'b0;
    end else if (m_axis_tvalid && m_axis_tready) begin
      draw = rx_burst ? 0 : $urandom_range(0, 8);
      m_axis_tready <= (draw == 0);
      rx_stall <= draw;
      if ($urandom_range(0, 29) == 0) rx_burst <= !rx_burst;
    end else if (rx_stall > 0) begin
      if (m_axis_tvalid) begin
        rx_stall <= rx_stall - 1;
        m_axis_tready <= (rx_stall == 1);
      end
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // register tracking, prediction and result checking
  always @(posedge clk) begin : check_side
    point_result_t got;
    point_result_t want;
    if (rst) begin
      julia_mode <= MODE_MANDELBROT;
      iter_count <= ITER_RESET;
      c_re <= '0;
      c_im <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_MODE: julia_mode <= cfg_data[0];
          CFG_ITER: iter_count <= cfg_data[ITER_BITS-1:0];
          CFG_CRE:  c_re <= cfg_data[WORD_WIDTH-1:0];
          CFG_CIM:  c_im <= cfg_data[WORD_WIDTH-1:0];
          default:  ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready)
        expected_results.push_back(iterate_point(s_axis_tdata[WORD_WIDTH-1:0],
                                                 s_axis_tdata[2*WORD_WIDTH-1:WORD_WIDTH]));
      if (m_axis_tvalid && m_axis_tready) begin
        got.re = m_axis_tdata[WORD_WIDTH-1:0];
        got.im = m_axis_tdata[2*WORD_WIDTH-1:WORD_WIDTH];
        got.escaped = m_axis_tuser;
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: unexpected item, expected none, got re=%h im=%h esc=%b",
                     $time, got.re, got.im, got.escaped);
        end else begin
          want = expected_results.pop_front();
          if (got.re !== want.re || got.im !== want.im || got.escaped !== want.escaped) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("%0t: mismatch, expected re=%h im=%h esc=%b, got re=%h im=%h esc=%b",
                       $time, want.re, want.im, want.escaped, got.re, got.im, got.escaped);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // upper bits of the narrow registers carry junk, which must be ignored
  task automatic set_config(input logic mode, input logic [ITER_BITS-1:0] iters,
                            input word_t cre, input word_t cim);
    logic [CFG_DATA_BITS-1:0] junk;
    junk = $urandom();
    junk[0] = mode;
    write_reg(CFG_MODE, junk);
    junk = $urandom();
    junk[ITER_BITS-1:0] = iters;
    write_reg(CFG_ITER, junk);
    write_reg(CFG_CRE, cre);
    write_reg(CFG_CIM, cim);
    if ($urandom_range(0, 3) == 0)
      write_reg(CFG_INDEX_BITS'($urandom_range(4, 2**CFG_INDEX_BITS - 1)), $urandom());
    @(negedge clk);
  endtask

  task automatic queue_point(input word_t p_re, input word_t p_im);
    pending_points.push_back({p_im, p_re});
    points_queued++;
  endtask

  task automatic drain(input int settle);
    do @(negedge clk);
    while (pending_points.size() != 0 || s_axis_tvalid || expected_results.size() != 0);
    repeat (settle) @(negedge clk);
  endtask

  initial begin
    int                   n_points;
    logic                 mode;
    logic [ITER_BITS-1:0] iters;

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // registers at their reset values: Mandelbrot, 100 iterations
    queue_point('0, '0);
    queue_point(word_t'(-2 * FP_ONE), '0);      // settles exactly at 2.0
    queue_point(FP_ONE >>> 2, '0);               // slow approach to 0.5
    queue_point('0, FP_ONE);                     // cycles through i, -1+i, -i
    queue_point(word_t'(-FP_ONE), '0);
    queue_point(W_MIN, W_MIN);
    queue_point(W_MAX, W_MAX);
    queue_point(W_MIN, W_MAX);
    queue_point(W_MAX, W_MIN);
    queue_point(W_MIN, '0);
    queue_point(word_t'(32'h5555_5555), word_t'(32'hAAAA_AAAA));
    drain(4);

    // no iterations: result is the starting z
    set_config(MODE_MANDELBROT, '0, W_MAX, W_MIN);
    queue_point(W_MAX, W_MIN);
    queue_point(word_t'(32'hAAAA_AAAA), word_t'(32'h5555_5555));
    drain(4);
    set_config(MODE_JULIA, '0, W_MIN, W_MAX);
    queue_point(W_MIN, W_MAX);
    queue_point(word_t'(32'h1234_5678), word_t'(32'h9ABC_DEF0));
    drain(4);

    // Julia constant at the extremes, a single step
    set_config(MODE_JULIA, ITER_BITS'(1), W_MIN, W_MAX);
    queue_point('0, '0);
    queue_point(FP_ONE, '0);
    drain(4);
    set_config(MODE_JULIA, ITER_BITS'(1), W_MAX, W_MAX);
    queue_point(FP_ONE, '0);                     // real sum overflows
    queue_point('0, FP_ONE);
    drain(4);

    // doubled cross term overflow, square overflow, floor of a negative product
    set_config(MODE_JULIA, ITER_BITS'(1), '0, '0);
    queue_point(word_t'(2 * FP_ONE), word_t'(2 * FP_ONE));
    queue_point(word_t'(3 * FP_ONE), '0);
    queue_point(word_t'(-1), word_t'(1));
    drain(4);

    // longest count: one orbit that never escapes, one that escapes at once
    set_config(MODE_JULIA, {ITER_BITS{1'b1}}, '0, '0);
    queue_point('0, FP_ONE);
    queue_point(word_t'(3 * FP_ONE), '0);
    drain(4);

    while (points_queued < ITEM_TARGET) begin
      mode = 1'($urandom_range(0, 1));
      if ($urandom_range(0, 3) != 0) begin
        iters = ITER_BITS'($urandom_range(0, 16));
        n_points = 40;
      end else begin
        iters = ITER_BITS'($urandom_range(17, 300));
        n_points = 8;
      end
      set_config(mode, iters, rand_coord(), rand_coord());
      repeat (n_points) queue_point(rand_coord(), rand_coord());
      drain(4);
    end

    // a few points at a large random count
    set_config(1'($urandom_range(0, 1)), ITER_BITS'($urandom_range(1024, 4095)),
               rand_coord(), rand_coord());
    repeat (3) queue_point(rand_coord(), rand_coord());
    drain(50);

    if (mismatches == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

// File: sim.f
rtl/fpi_pkg.sv
rtl/fpi_cfg_regs.sv
rtl/fpi_serial_mult.sv
rtl/fractal_point_iterator_core.sv
tb/sv/fractal_point_iterator_core_tb.sv
